// ===== design/mpm_pkg.sv =====
`timescale 1ns / 1ps

package mpm_pkg;

  localparam int MOUNTS      = 8;
  localparam int PREFIX_MAX  = 64;
  localparam int PATH_CHARS  = 256;
  localparam int MAX_MATCHES = 4;

  localparam int CMD_W      = 2;
  localparam int ENTRY_W    = 3;
  localparam int POSITION_W = 6;
  localparam int CHAR_W     = 8;
  localparam int PLEN_IN_W  = 7;
  localparam int MIDX_OUT_W = 3;
  localparam int RANK_W     = 2;
  localparam int COUNT_W    = 3;

  localparam int MOUNT_W = (MOUNTS > 1) ? $clog2(MOUNTS) : 1;
  localparam int ADDR_W  = $clog2(PREFIX_MAX);
  localparam int LEN_W   = $clog2(PREFIX_MAX + 1);
  localparam int PPOS_W  = $clog2(PATH_CHARS + 1);
  localparam int SLOT_W  = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
  localparam int CNT_W   = $clog2(MAX_MATCHES + 1);
  localparam int LCMP_W  = (LEN_W > PLEN_IN_W) ? LEN_W : PLEN_IN_W;
  localparam int PCMP_W  = (PPOS_W > LEN_W) ? PPOS_W : LEN_W;
  localparam int AEXT_W  = (PPOS_W > ADDR_W) ? PPOS_W : ADDR_W;

  localparam logic [CHAR_W-1:0] SLASH = 8'h2F;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_CHAR = 2'd0,
    CMD_SET_ENTRY  = 2'd1,
    CMD_PATH_CHAR  = 2'd2
  } mpm_command_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_SCAN,
    S_EMIT
  } mpm_state_t;

  typedef struct packed {
    logic wr_char;
    logic set_entry;
    logic path_start;
    logic path_compare;
    logic scan_clear;
    logic scan_step;
    logic path_done;
    logic emit_load;
  } mpm_cmd_t;

  typedef struct packed {
    logic last_char;
    logic scan_last;
    logic emit_last;
    logic out_free;
  } mpm_status_t;

endpackage

// ===== design/mount_prefix_matcher_core.sv =====
`timescale 1ns / 1ps
// Table writes (prefix character, entry flags): accepted without stalling the input.
// Path character: lane memory read, then compare in all lanes; input stalled meanwhile.
// Final path character: read and compare, then one entry sorted per cycle before the
// first result; then one result per cycle while the output is not stalled.
// Reset (rst, synchronous): entries unused, all lanes alive, path position zero.
module mount_prefix_matcher_core
  import mpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      command,
  input  logic [ENTRY_W-1:0]    entry,
  input  logic [POSITION_W-1:0] position,
  input  logic [CHAR_W-1:0]     char_value,
  input  logic                  entry_used,
  input  logic                  has_device,
  input  logic [PLEN_IN_W-1:0]  prefix_length,
  input  logic                  last_char,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  found,
  output logic [MIDX_OUT_W-1:0] mount_index,
  output logic [RANK_W-1:0]     rank,
  output logic [COUNT_W-1:0]    match_count,
  output logic                  last_result
);

  mpm_cmd_t    cmd;
  mpm_status_t sts;

  mpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  mpm_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .entry         (entry),
    .position      (position),
    .char_value    (char_value),
    .entry_used    (entry_used),
    .has_device    (has_device),
    .prefix_length (prefix_length),
    .last_char     (last_char),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .found         (found),
    .mount_index   (mount_index),
    .rank          (rank),
    .match_count   (match_count),
    .last_result   (last_result)
  );

endmodule

// ===== design/mpm_lane.sv =====
`timescale 1ns / 1ps

module mpm_lane
  import mpm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [CHAR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [PPOS_W-1:0] pos,
  input  logic              cmp_en,
  input  logic [CHAR_W-1:0] ch,
  input  logic [LEN_W-1:0]  len,
  input  logic              revive,
  output logic              alive,
  output logic              root_slash
);

  logic [CHAR_W-1:0] mem [PREFIX_MAX];
  logic [CHAR_W-1:0] rd_data;
  logic [AEXT_W-1:0] pos_ext;
  logic [PCMP_W-1:0] pos_cmp;
  logic [PCMP_W-1:0] len_cmp;
  logic              kill;

  assign pos_ext = AEXT_W'(pos);
  assign pos_cmp = PCMP_W'(pos);
  assign len_cmp = PCMP_W'(len);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[pos_ext[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_slash <= 1'b0;
    end else if (wr_en && wr_addr == '0) begin
      root_slash <= (wr_data == SLASH);
    end
  end

  always_comb begin
    if (pos_cmp < len_cmp) begin
      kill = (rd_data != ch);
    end else if (pos_cmp == len_cmp) begin
      kill = (ch != SLASH);
    end else begin
      kill = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b1;
    end else if (revive) begin
      alive <= 1'b1;
    end else if (cmp_en && kill) begin
      alive <= 1'b0;
    end
  end

endmodule

// ===== design/mpm_datapath.sv =====
`timescale 1ns / 1ps

module mpm_datapath
  import mpm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  mpm_cmd_t              cmd,
  output mpm_status_t           sts,
  input  logic [ENTRY_W-1:0]    entry,
  input  logic [POSITION_W-1:0] position,
  input  logic [CHAR_W-1:0]     char_value,
  input  logic                  entry_used,
  input  logic                  has_device,
  input  logic [PLEN_IN_W-1:0]  prefix_length,
  input  logic                  last_char,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  found,
  output logic [MIDX_OUT_W-1:0] mount_index,
  output logic [RANK_W-1:0]     rank,
  output logic [COUNT_W-1:0]    match_count,
  output logic                  last_result
);

  logic [MOUNTS-1:0]  entry_valid;
  logic [MOUNTS-1:0]  entry_device;
  logic [LEN_W-1:0]   entry_length [MOUNTS];
  logic [PPOS_W-1:0]  path_pos;
  logic [CHAR_W-1:0]  ch;
  logic               last_q;

  logic [MOUNTS-1:0]  alive;
  logic [MOUNTS-1:0]  root_slash;
  logic [MOUNTS-1:0]  hit;
  logic               entry_ok;
  logic               pos_ok;
  logic               pos_in_range;
  logic [LEN_W-1:0]   len_sat;

  logic [MOUNT_W-1:0] scan_idx;
  logic [CNT_W-1:0]   count;
  logic [SLOT_W-1:0]  emit_idx;
  logic [MOUNT_W-1:0] slot_idx [MAX_MATCHES];
  logic [LEN_W-1:0]   slot_len [MAX_MATCHES];
  logic               slot_dev [MAX_MATCHES];
  logic [MAX_MATCHES-1:0] take;
  logic [MAX_MATCHES-1:0] prev_take;
  logic [LEN_W-1:0]   cur_len;
  logic               cur_dev;
  logic               ins;

  assign entry_ok     = int'(entry) < MOUNTS;
  assign pos_ok       = int'(position) < PREFIX_MAX;
  assign pos_in_range = path_pos < PPOS_W'(PATH_CHARS);
  assign len_sat      = (LCMP_W'(prefix_length) > LCMP_W'(PREFIX_MAX)) ?
                        LEN_W'(PREFIX_MAX) : LEN_W'(prefix_length);

  for (genvar e = 0; e < MOUNTS; e++) begin : g_lane
    mpm_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .wr_en      (cmd.wr_char && entry_ok && pos_ok && int'(entry) == e),
      .wr_addr    (ADDR_W'(position)),
      .wr_data    (char_value),
      .rd_en      (cmd.path_start),
      .pos        (path_pos),
      .cmp_en     (cmd.path_compare && pos_in_range),
      .ch         (ch),
      .len        (entry_length[e]),
      .revive     (cmd.path_done),
      .alive      (alive[e]),
      .root_slash (root_slash[e])
    );

    assign hit[e] = entry_valid[e] &&
                    ((entry_length[e] == LEN_W'(1) && root_slash[e]) ||
                     (alive[e] && PCMP_W'(path_pos) >= PCMP_W'(entry_length[e])));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      entry_device <= '0;
    end else if (cmd.set_entry && entry_ok) begin
      entry_valid[MOUNT_W'(entry)]  <= entry_used;
      entry_device[MOUNT_W'(entry)] <= has_device;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_entry && entry_ok) begin
      entry_length[MOUNT_W'(entry)] <= len_sat;
    end
    if (cmd.path_start) begin
      ch     <= char_value;
      last_q <= last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_pos <= '0;
    end else if (cmd.path_done) begin
      path_pos <= '0;
    end else if (cmd.path_compare && pos_in_range) begin
      path_pos <= path_pos + PPOS_W'(1);
    end
  end

  // insertion sort of hits into the result slots, one entry per cycle
  assign cur_len = entry_length[scan_idx];
  assign cur_dev = entry_device[scan_idx];
  assign ins     = cmd.scan_step && hit[scan_idx] && count < CNT_W'(MAX_MATCHES);

  always_comb begin
    for (int i = 0; i < MAX_MATCHES; i++) begin
      take[i] = (CNT_W'(i) >= count) || (cur_len > slot_len[i]) ||
                (cur_len == slot_len[i] && cur_dev && !slot_dev[i]);
    end
    prev_take[0] = 1'b0;
    for (int i = 1; i < MAX_MATCHES; i++) begin
      prev_take[i] = take[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      if (take[0]) begin
        slot_idx[0] <= scan_idx;
        slot_len[0] <= cur_len;
        slot_dev[0] <= cur_dev;
      end
      for (int i = 1; i < MAX_MATCHES; i++) begin
        if (take[i]) begin
          if (prev_take[i]) begin
            slot_idx[i] <= slot_idx[i-1];
            slot_len[i] <= slot_len[i-1];
            slot_dev[i] <= slot_dev[i-1];
          end else begin
            slot_idx[i] <= scan_idx;
            slot_len[i] <= cur_len;
            slot_dev[i] <= cur_dev;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      count    <= '0;
    end else if (cmd.scan_clear) begin
      scan_idx <= '0;
      count    <= '0;
    end else if (cmd.scan_step) begin
      if (!sts.scan_last) begin
        scan_idx <= scan_idx + MOUNT_W'(1);
      end
      if (ins) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx <= '0;
    end else if (cmd.path_done) begin
      emit_idx <= '0;
    end else if (cmd.emit_load) begin
      emit_idx <= emit_idx + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      found       <= (count != '0);
      mount_index <= (count != '0) ? MIDX_OUT_W'(slot_idx[emit_idx]) : '0;
      rank        <= RANK_W'(emit_idx);
      match_count <= COUNT_W'(count);
      last_result <= sts.emit_last;
    end
  end

  assign sts.last_char = last_q;
  assign sts.scan_last = (int'(scan_idx) == MOUNTS - 1);
  assign sts.emit_last = (count == '0) || (CNT_W'(emit_idx) + CNT_W'(1) == count);
  assign sts.out_free  = !out_valid || !out_stall;

endmodule

// ===== design/mpm_ctrl.sv =====
`timescale 1ns / 1ps

module mpm_ctrl
  import mpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] command,
  input  mpm_status_t      sts,
  output mpm_cmd_t         cmd,
  output logic             in_stall
);

  mpm_state_t state;
  mpm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (command)
            CMD_WRITE_CHAR: cmd.wr_char = 1'b1;
            CMD_SET_ENTRY:  cmd.set_entry = 1'b1;
            CMD_PATH_CHAR: begin
              cmd.path_start = 1'b1;
              state_next     = S_COMPARE;
            end
            default: ;
          endcase
        end
      end
      S_COMPARE: begin
        cmd.path_compare = 1'b1;
        if (sts.last_char) begin
          cmd.scan_clear = 1'b1;
          state_next     = S_SCAN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          cmd.path_done = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== design/mpm_checker.sv =====
`timescale 1ns / 1ps

module mpm_checker
  import mpm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [CMD_W-1:0]      command,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  found,
  input logic [MIDX_OUT_W-1:0] mount_index,
  input logic [RANK_W-1:0]     rank,
  input logic [COUNT_W-1:0]    match_count,
  input logic                  last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(mount_index) &&
      $stable(rank) && $stable(match_count) && $stable(last_result))
    else $error("stalled result changed");

  a_path_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_PATH_CHAR |=> in_stall)
    else $error("path request not held off during compare");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> last_result && match_count == '0 && rank == '0)
    else $error("bad not-found result");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> match_count != '0 && COUNT_W'(rank) < match_count)
    else $error("rank beyond match count");

  a_last_rank: assert property (@(posedge clk) disable iff (rst)
    out_valid && found && last_result |-> COUNT_W'(rank) + COUNT_W'(1) == match_count)
    else $error("final result rank mismatch");

endmodule

bind mount_prefix_matcher_core mpm_checker u_mpm_checker (.*);
